// File: rtl/core/nms_pkg.sv
// Package for the Canny non-maximum suppression block: sizes, codes, shared types.
// No dependencies; every other file in rtl/core imports it.
`default_nettype none
package nms_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 21;
    localparam int SQ_W       = 2 * CFG_W;
    localparam int AREA_W     = COL_W + ROW_W + 1;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);
    localparam logic [CFG_W-1:0] RST_HIGH   = CFG_W'(90);
    localparam logic [CFG_W-1:0] RST_LOW    = CFG_W'(45);

    // fixed-point tangents of 22.5 and 67.5 degrees, scaled by 128
    localparam int TAN_LO = 53;
    localparam int TAN_HI = 309;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_HIGH_THRESH  = 2'd2,
        CFG_LOW_THRESH   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEC_H = 2'd0,
        SEC_D = 2'd1,
        SEC_V = 2'd2,
        SEC_A = 2'd3
    } sector_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_WEAK   = 2'd1,
        CLS_STRONG = 2'd2
    } edge_cls_t;

    // control that travels with an item from classification to the window
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] cc;
        logic [COL_W-1:0] cr;
        logic             nb_l;
        logic             nb_r;
        logic             nb_u;
        logic             nb_d;
    } ctl_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        sector_t          sec;
        logic [COL_W-1:0] idx;
        ctl_t             ctl;
    } item_t;

    typedef struct packed {
        logic [SQ_W-1:0] high_sq;
        logic [SQ_W-1:0] low_sq;
    } thr_t;

endpackage
`default_nettype wire

// File: rtl/core/nms_in_if.sv
// Input channel: valid/ready handshake carrying one gradient item.
// Depends on nms_pkg.
`default_nettype none
interface nms_in_if import nms_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;

    modport source (output valid, req_type, grad_x, grad_y, input ready);
    modport sink   (input valid, req_type, grad_x, grad_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nms_out_if.sv
// Output channel: valid/ready handshake carrying one suppressed result item.
// Depends on nms_pkg.
`default_nettype none
interface nms_out_if import nms_pkg::*;;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] pix_col;
    logic [COL_W-1:0] pix_row;
    logic [MAG_W-1:0] suppressed_mag_sq;
    logic [1:0]       edge_class;
    logic             frame_last;

    modport source (output valid, pix_col, pix_row, suppressed_mag_sq, edge_class,
                    frame_last, input ready);
    modport sink   (input valid, pix_col, pix_row, suppressed_mag_sq, edge_class,
                    frame_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nms_front.sv
// Front end: configuration registers, item acceptance, magnitude and sector,
// raster counters and frame bookkeeping. Depends on nms_pkg and nms_in_if.
`default_nettype none
module nms_front import nms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    nms_in_if.sink                    grad,
    input  wire logic                 q_full,
    output logic                      push,
    output item_t                     push_item,
    output thr_t                      thr
);

    logic [CFG_W-1:0]  fw_reg, fh_reg, hi_reg, lo_reg;
    logic [AREA_W-1:0] area_reg;
    logic [SQ_W-1:0]   hsq_reg, lsq_reg;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W:0]    in_row_reg, in_row_next;
    logic [AREA_W-2:0] out_cnt_reg, out_cnt_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [COL_W-1:0]  out_row_reg, out_row_next;

    logic [CFG_W-1:0]    w, h;
    logic                accept, input_done, drop, emit, last;
    logic [GRAD_W-1:0]   ax, ay;
    logic [2*GRAD_W:0]   mag_sum;
    logic [MAG_W-1:0]    new_mag;
    sector_t             new_sec;
    logic [GRAD_W+8:0]   ay_s, ax_lo, ax_hi;
    logic [AREA_W+1:0]   pos;
    logic [AREA_W-1:0]   out_cnt_inc;

    always_comb
    begin
        if (fw_reg == '0)
            w = CFG_W'(1);
        else if (fw_reg > CFG_W'(MAX_WIDTH))
            w = CFG_W'(MAX_WIDTH);
        else
            w = fw_reg;
        if (fh_reg == '0)
            h = CFG_W'(1);
        else if (fh_reg > CFG_W'(MAX_HEIGHT))
            h = CFG_W'(MAX_HEIGHT);
        else
            h = fh_reg;
    end

    assign grad.ready = !q_full;
    assign accept     = grad.valid && grad.ready;
    assign input_done = in_row_reg >= (ROW_W+1)'(h);
    assign drop       = grad.req_type && !input_done;

    // magnitude and direction sector
    assign ax = grad.grad_x[GRAD_W-1] ? GRAD_W'(-grad.grad_x) : GRAD_W'(grad.grad_x);
    assign ay = grad.grad_y[GRAD_W-1] ? GRAD_W'(-grad.grad_y) : GRAD_W'(grad.grad_y);
    assign mag_sum = (2*GRAD_W+1)'(ax * ax) + (2*GRAD_W+1)'(ay * ay);
    assign ay_s  = (GRAD_W+9)'({ay, 7'b0});
    assign ax_lo = (GRAD_W+9)'(ax * (GRAD_W+9)'(TAN_LO));
    assign ax_hi = (GRAD_W+9)'(ax * (GRAD_W+9)'(TAN_HI));

    always_comb
    begin
        new_mag = '0;
        new_sec = SEC_H;
        if (!input_done)
        begin
            new_mag = (mag_sum > (2*GRAD_W+1)'(MAG_MAX)) ? MAG_MAX : MAG_W'(mag_sum);
            if (ax == '0)
                new_sec = SEC_V;
            else if (ay_s <= ax_lo)
                new_sec = SEC_H;
            else if (ay_s > ax_hi)
                new_sec = SEC_V;
            else if (grad.grad_x[GRAD_W-1] == grad.grad_y[GRAD_W-1])
                new_sec = SEC_D;
            else
                new_sec = SEC_A;
        end
    end

    assign pos = (AREA_W+2)'(in_row_reg * w) + (AREA_W+2)'(in_col_reg);
    assign emit = pos >= (AREA_W+2)'(w) + (AREA_W+2)'(1);
    assign out_cnt_inc = AREA_W'(out_cnt_reg) + AREA_W'(1);
    assign last = emit && (out_cnt_inc >= area_reg);

    always_comb
    begin
        push_item.mag      = new_mag;
        push_item.sec      = new_sec;
        push_item.idx      = in_col_reg;
        push_item.ctl.emit = emit;
        push_item.ctl.last = last;
        push_item.ctl.cc   = out_col_reg;
        push_item.ctl.cr   = out_row_reg;
        push_item.ctl.nb_l = out_col_reg != '0;
        push_item.ctl.nb_r = (CFG_W'(out_col_reg) + CFG_W'(1)) < w;
        push_item.ctl.nb_u = out_row_reg != '0;
        push_item.ctl.nb_d = (CFG_W'(out_row_reg) + CFG_W'(1)) < h;
    end
    assign push = accept && !drop;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_cnt_next = out_cnt_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (push)
        begin
            if ((CFG_W'(in_col_reg) + CFG_W'(1)) >= w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + (ROW_W+1)'(1);
            end
            else
                in_col_next = in_col_reg + COL_W'(1);
            if (emit)
            begin
                out_cnt_next = (AREA_W-1)'(out_cnt_inc);
                if ((CFG_W'(out_col_reg) + CFG_W'(1)) >= w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + COL_W'(1);
                end
                else
                    out_col_next = out_col_reg + COL_W'(1);
            end
            // frame done: restart all counters
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_cnt_next = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= RST_WIDTH;
            fh_reg      <= RST_HEIGHT;
            hi_reg      <= RST_HIGH;
            lo_reg      <= RST_LOW;
            area_reg    <= AREA_W'(RST_WIDTH * RST_HEIGHT);
            hsq_reg     <= SQ_W'(RST_HIGH * RST_HIGH);
            lsq_reg     <= SQ_W'(RST_LOW * RST_LOW);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_cnt_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    CFG_HIGH_THRESH:  hi_reg <= cfg_data;
                    CFG_LOW_THRESH:   lo_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
            end
            area_reg    <= AREA_W'(w * h);
            hsq_reg     <= SQ_W'(hi_reg * hi_reg);
            lsq_reg     <= SQ_W'(lo_reg * lo_reg);
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_cnt_reg <= out_cnt_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign thr.high_sq = hsq_reg;
    assign thr.low_sq  = lsq_reg;

endmodule
`default_nettype wire

// File: rtl/core/nms_queue.sv
// Two-entry queue between the front end and the window stage.
// Depends on nms_pkg.
`default_nettype none
module nms_queue import nms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    input  wire logic  pop,
    output item_t      head,
    output logic       not_empty,
    output logic       full
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign do_pop    = pop && not_empty;
    assign not_empty = cnt_reg != 2'd0;
    assign full      = cnt_reg == 2'd2;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/nms_back.sv
// Back end: line buffers, 3x3 magnitude window, suppression, threshold class
// and output register. Depends on nms_pkg and nms_out_if.
`default_nettype none
module nms_back import nms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  item_t      head,
    input  wire logic  head_valid,
    output logic       pop,
    input  thr_t       thr,
    nms_out_if.source  result
);

    logic [MAG_W-1:0] line_a [MAX_WIDTH];
    logic [MAG_W-1:0] line_b [MAX_WIDTH];
    sector_t          sec_line [MAX_WIDTH];

    logic             adv;
    logic             s1_valid_reg, s2_valid_reg;
    ctl_t             s1_ctl_reg, s2_ctl_reg;
    logic [MAG_W-1:0] s1_mag_reg, rd_a_reg, rd_b_reg;
    sector_t          rd_s_reg, held_sec_reg, csec_reg;
    logic [MAG_W-1:0] win_reg [9];

    logic             sup;
    logic [MAG_W-1:0] c, val;
    edge_cls_t        cls;

    logic             o_valid_reg;
    logic [COL_W-1:0] o_col_reg, o_row_reg;
    logic [MAG_W-1:0] o_mag_reg;
    edge_cls_t        o_cls_reg;
    logic             o_last_reg;

    // advance the whole back end whenever the output register is free
    assign adv = !o_valid_reg || result.ready;
    assign pop = adv && head_valid;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_a_reg          <= line_a[head.idx];
            rd_b_reg          <= line_b[head.idx];
            rd_s_reg          <= sec_line[head.idx];
            line_b[head.idx]  <= line_a[head.idx];
            line_a[head.idx]  <= head.mag;
            sec_line[head.idx] <= head.sec;
            s1_mag_reg        <= head.mag;
            s1_ctl_reg        <= head.ctl;
        end
        if (adv && s1_valid_reg)
            s2_ctl_reg <= s1_ctl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            held_sec_reg <= SEC_H;
            csec_reg     <= SEC_H;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2]   <= rd_b_reg;
                win_reg[5]   <= rd_a_reg;
                win_reg[8]   <= s1_mag_reg;
                csec_reg     <= held_sec_reg;
                held_sec_reg <= rd_s_reg;
            end
        end
    end

    assign c = win_reg[4];

    always_comb
    begin
        unique case (csec_reg)
            SEC_H: sup = (s2_ctl_reg.nb_l && c <= win_reg[3]) ||
                         (s2_ctl_reg.nb_r && c <= win_reg[5]);
            SEC_V: sup = (s2_ctl_reg.nb_u && c <= win_reg[1]) ||
                         (s2_ctl_reg.nb_d && c <= win_reg[7]);
            SEC_D: sup = (s2_ctl_reg.nb_u && s2_ctl_reg.nb_l && c <= win_reg[0]) ||
                         (s2_ctl_reg.nb_d && s2_ctl_reg.nb_r && c <= win_reg[8]);
            SEC_A: sup = (s2_ctl_reg.nb_u && s2_ctl_reg.nb_r && c <= win_reg[2]) ||
                         (s2_ctl_reg.nb_d && s2_ctl_reg.nb_l && c <= win_reg[6]);
            default: sup = 1'b0;
        endcase
        val = sup ? '0 : c;
        if (SQ_W'(val) >= thr.high_sq)
            cls = CLS_STRONG;
        else if (SQ_W'(val) > thr.low_sq)
            cls = CLS_WEAK;
        else
            cls = CLS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= s2_valid_reg && s2_ctl_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && s2_ctl_reg.emit)
        begin
            o_col_reg  <= s2_ctl_reg.cc;
            o_row_reg  <= s2_ctl_reg.cr;
            o_mag_reg  <= val;
            o_cls_reg  <= cls;
            o_last_reg <= s2_ctl_reg.last;
        end
    end

    assign result.valid             = o_valid_reg;
    assign result.pix_col           = o_col_reg;
    assign result.pix_row           = o_row_reg;
    assign result.suppressed_mag_sq = o_mag_reg;
    assign result.edge_class        = o_cls_reg;
    assign result.frame_last        = o_last_reg;

endmodule
`default_nettype wire

// File: rtl/core/canny_nonmax_suppression_unit.sv
// Top level of the Canny non-maximum suppression block.
// Depends on nms_pkg, nms_in_if, nms_out_if, nms_front, nms_queue and nms_back.
//
// Use: feed Sobel gradient pairs in raster order on the grad channel
// (req_type 0), then flush items (req_type 1) until the result with
// frame_last arrives; each item yields at most one result on the result
// channel. A centre pixel is reported one row and one pixel after it came in,
// so a frame of W x H pixels needs W+1 flush items at its end. Flush items
// sent before the frame is complete are taken and dropped.
// Throughput: one item per clock while the receiver takes results.
// Path from the accepted item to the result showing valid: queue pop with line
// buffer read, window, output register, in that order.
// Write the four registers through cfg_we/cfg_index/cfg_data only while idle.
// Reset: counters, window and queue clear, the registers take their defaults
// (640 x 480, thresholds 90 and 45); the line buffers are not cleared.
// Receiver stall: the output register holds; the back end freezes and the
// two-entry queue fills, after which grad.ready drops.
`default_nettype none
module canny_nonmax_suppression_unit import nms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    nms_in_if.sink                    grad,
    nms_out_if.source                 result
);

    item_t push_item, head;
    logic  push, pop, q_full, q_not_empty;
    thr_t  thr;

    // classify items and keep the raster counters
    nms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .grad      (grad),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .thr       (thr)
    );

    // decouple the front end from back-end stalls
    nms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // window, suppression and output register
    nms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_not_empty),
        .pop        (pop),
        .thr        (thr),
        .result     (result)
    );

endmodule
`default_nettype wire

// File: rtl/core/nms_checker.sv
// Port-level checker for the Canny non-maximum suppression block, bound to
// the top level. Depends on nms_pkg.
`default_nettype none
module nms_checker import nms_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [MAG_W-1:0] out_mag,
    input wire logic [1:0]       out_cls,
    input wire logic             out_last
);

    // hold a stalled result
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_mag) && $stable(out_cls) && $stable(out_last))
        else $error("result changed while stalled");

    a_cls_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_cls != CLS_STRONG + 2'd1)
        else $error("illegal edge class");

    a_weak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_cls == CLS_WEAK |-> out_mag != '0)
        else $error("weak edge with zero magnitude");

endmodule

bind canny_nonmax_suppression_unit nms_checker u_nms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_mag   (result.suppressed_mag_sq),
    .out_cls   (result.edge_class),
    .out_last  (result.frame_last)
);
`default_nettype wire
